/* rtl/frt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared request, response and slot record types, status codes, constants and a
// sequence comparison function.
package frt_pkg;

  localparam int unsigned ENTRIES_DEF       = 256;
  localparam int unsigned MAX_FRAGMENTS_DEF = 256;

  localparam logic [10:0] MAX_FRAG_SIZE_RST = 11'd1024;
  localparam logic [14:0] MAX_SEQ_DIST_RST  = 15'd10240;
  localparam logic [8:0]  MAX_BUFFERED_RST  = 9'd256;

  localparam logic [1:0] CFG_MAX_FRAG_SIZE = 2'd0;
  localparam logic [1:0] CFG_MAX_SEQ_DIST  = 2'd1;
  localparam logic [1:0] CFG_MAX_BUFFERED  = 2'd2;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_FULL         = 4'd1;
  localparam logic [3:0] ST_EMPTY        = 4'd2;
  localparam logic [3:0] ST_OVERSIZE     = 4'd3;
  localparam logic [3:0] ST_BAD_COUNT    = 4'd4;
  localparam logic [3:0] ST_BAD_INDEX    = 4'd5;
  localparam logic [3:0] ST_SHORT        = 4'd6;
  localparam logic [3:0] ST_TOO_FAR      = 4'd7;
  localparam logic [3:0] ST_SLOT_TAKEN   = 4'd8;
  localparam logic [3:0] ST_COUNT_DIFF   = 4'd9;
  localparam logic [3:0] ST_DUPLICATE    = 4'd10;

  typedef struct packed {
    logic [15:0] sequence_req;
    logic [7:0]  fragment_index;
    logic [7:0]  fragment_count;
    logic [10:0] fragment_size;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        packet_complete;
    logic [15:0] complete_sequence;
    logic [18:0] complete_size;
  } rsp_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  frag_count;
    logic [7:0]  recv_count;
    logic [10:0] last_size;
  } meta_t;

  // True when sequence a is newer than sequence b in wrapped arithmetic.
  function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] dab;
    logic [15:0] dba;
    dab = a - b;
    dba = b - a;
    return ((a > b) && (dab <= 16'h8000)) || ((a < b) && (dba > 16'h8000));
  endfunction

endpackage

/* rtl/frt_meta_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot record memory
// One write port and one registered read port holding each slot's record.
// ----------------------------------------------------------------------------
module frt_meta_mem #(
  parameter int unsigned DEPTH = frt_pkg::ENTRIES_DEF,
  parameter int unsigned AW    = $clog2(frt_pkg::ENTRIES_DEF)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  frt_pkg::meta_t      wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output frt_pkg::meta_t      rdata_o
);

  frt_pkg::meta_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/frt_mark_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Received mark memory
// 64-bit words of per-fragment received marks, one write and one read port.
// ----------------------------------------------------------------------------
module frt_mark_mem #(
  parameter int unsigned DEPTH = frt_pkg::ENTRIES_DEF * 4,
  parameter int unsigned AW    = $clog2(frt_pkg::ENTRIES_DEF * 4)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  logic [63:0]    wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output logic [63:0]    rdata_o
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/fragment_reassembly_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Checks fragment descriptors, tracks received fragments per slot and reports
// completed packets with their total size.
// ----------------------------------------------------------------------------
// Each request is one fragment descriptor and gives exactly one response, in
// order. The block handles one request at a time. A request that is rejected
// goes from accept to the response register through these steps: the slot
// index (sequence modulo ENTRIES through a reciprocal multiply), a read of
// the slot record and mark word, the checks, and loading the response. A
// request recorded in a slot that is already open also updates the slot
// before the response. Opening a new slot clears each 64-bit mark word of a
// slot (MAX_FRAGMENTS / 64, rounded up) in turn. Opening a slot for a
// sequence newer than any seen so far also walks every slot record once to
// retire stale slots; this walk through the single read port of the slot
// record memory sets the worst case. The next request is taken while a
// response still waits for its consumer. After reset no clearing pass is
// needed: slot valid bits sit in flip-flops and a slot's marks are cleared
// when it opens.
module fragment_reassembly_tracker #(
  parameter int unsigned ENTRIES       = frt_pkg::ENTRIES_DEF,
  parameter int unsigned MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  frt_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output frt_pkg::rsp_t  out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [14:0]    cfg_data_i
);

  localparam int unsigned SLOT_W     = $clog2(ENTRIES);
  localparam int unsigned MARK_WORDS = (MAX_FRAGMENTS + 63) / 64;
  localparam int unsigned WORD_W     = (MARK_WORDS > 1) ? $clog2(MARK_WORDS) : 1;
  localparam int unsigned MARK_AW    = SLOT_W + WORD_W;
  localparam longint unsigned RECIP_L = (64'd1 << 32) / ENTRIES;
  localparam logic [31:0] RECIP      = RECIP_L[31:0];
  localparam logic [15:0] ENTRIES_16 = 16'(ENTRIES);
  localparam logic [15:0] OLD_OFFSET = 16'(65536 - ENTRIES + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MARK_WORDS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD1 = 4'd1;
  localparam logic [3:0] S_MOD2 = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_ADV  = 4'd5;
  localparam logic [3:0] S_ADVE = 4'd6;
  localparam logic [3:0] S_CLR  = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Control state.
  logic [3:0]        state_q, state_d;
  logic [15:0]       newest_q, newest_d;
  logic [8:0]        buffered_q, buffered_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [10:0]       mfs_q;
  logic [14:0]       mdist_q;
  logic [8:0]        mbuf_q;
  logic              out_valid_q, out_valid_d;
  logic              ev_q, ev_d;

  // Working registers of the current request.
  frt_pkg::req_t     req_q, req_d;
  logic [47:0]       prod_q, prod_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [3:0]        early_q, early_d;
  logic [SLOT_W-1:0] walk_q, walk_d;
  logic [SLOT_W-1:0] ev_idx_q, ev_idx_d;
  logic [WORD_W-1:0] clr_q, clr_d;
  logic [7:0]        old_recv_q, old_recv_d;
  logic [10:0]       old_last_q, old_last_d;
  logic [63:0]       mword_q, mword_d;
  frt_pkg::rsp_t     res_q, res_d;
  frt_pkg::rsp_t     out_q, out_d;

  // Memory ports.
  logic              meta_we;
  logic [SLOT_W-1:0] meta_waddr, meta_raddr;
  frt_pkg::meta_t    meta_wdata, meta_rdata;
  logic              mark_we;
  logic [MARK_AW-1:0] mark_waddr, mark_raddr;
  logic [63:0]       mark_wdata, mark_rdata;

  // Per-request derived values.
  logic [WORD_W-1:0] word_sel;
  logic [63:0]       bit_sel;
  logic [15:0]       qest;
  logic [15:0]       rem0;
  logic [15:0]       rem1;
  logic [15:0]       seq_gap;
  logic              ahead;
  logic [3:0]        early_c;
  logic [15:0]       oldest;
  logic [7:0]        new_recv;
  logic [10:0]       new_last;
  logic [8:0]        buf_inc;
  logic [19:0]       total;

  frt_meta_mem #(
    .DEPTH (ENTRIES),
    .AW    (SLOT_W)
  ) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  frt_mark_mem #(
    .DEPTH (ENTRIES << WORD_W),
    .AW    (MARK_AW)
  ) u_mark (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The index is below the count, which never exceeds MAX_FRAGMENTS, so the
  // word number of a passing fragment always lies inside the slot.
  assign word_sel = WORD_W'(req_q.fragment_index >> 6);
  assign bit_sel  = 64'd1 << req_q.fragment_index[5:0];

  // Sequence modulo ENTRIES: the estimate is the true quotient or one below.
  assign qest = prod_q[47:32];
  assign rem0 = req_q.sequence_req - 16'(32'(qest) * 32'(ENTRIES));
  assign rem1 = (rem0 >= ENTRIES_16) ? (rem0 - ENTRIES_16) : rem0;

  // Wrapped distance ahead of the newest sequence; half the range counts as
  // ahead only when the sequence is numerically below the newest.
  assign seq_gap = req_q.sequence_req - newest_q;
  assign ahead   = (seq_gap < 16'h8000) ||
                   ((seq_gap == 16'h8000) && (req_q.sequence_req < newest_q));

  always_comb begin
    if (buffered_q >= mbuf_q) begin
      early_c = frt_pkg::ST_FULL;
    end else if (req_q.fragment_size == 11'd0) begin
      early_c = frt_pkg::ST_EMPTY;
    end else if (req_q.fragment_size > mfs_q) begin
      early_c = frt_pkg::ST_OVERSIZE;
    end else if ((req_q.fragment_count == 8'd0) ||
                 ({1'b0, req_q.fragment_count} > 9'(MAX_FRAGMENTS))) begin
      early_c = frt_pkg::ST_BAD_COUNT;
    end else if (req_q.fragment_index >= req_q.fragment_count) begin
      early_c = frt_pkg::ST_BAD_INDEX;
    end else if ((req_q.fragment_index != (req_q.fragment_count - 8'd1)) &&
                 (req_q.fragment_size != mfs_q)) begin
      early_c = frt_pkg::ST_SHORT;
    end else if (ahead && (seq_gap > {1'b0, mdist_q})) begin
      early_c = frt_pkg::ST_TOO_FAR;
    end else begin
      early_c = frt_pkg::ST_OK;
    end
  end

  // Slots whose sequence is older than this one fall out of the window.
  assign oldest = req_q.sequence_req + OLD_OFFSET;

  assign new_recv = old_recv_q + 8'd1;
  assign new_last = (req_q.fragment_index == (req_q.fragment_count - 8'd1)) ?
                    req_q.fragment_size : old_last_q;
  assign buf_inc  = (buffered_q < 9'd511) ? (buffered_q + 9'd1) : buffered_q;
  assign total    = 20'(19'(req_q.fragment_count - 8'd1) * 19'(mfs_q)) + 20'(new_last);

  always_comb begin
    state_d     = state_q;
    newest_d    = newest_q;
    buffered_d  = buffered_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    ev_d        = ev_q;
    req_d       = req_q;
    prod_d      = prod_q;
    slot_d      = slot_q;
    early_d     = early_q;
    walk_d      = walk_q;
    ev_idx_d    = ev_idx_q;
    clr_d       = clr_q;
    old_recv_d  = old_recv_q;
    old_last_d  = old_last_q;
    mword_d     = mword_q;
    res_d       = res_q;
    out_d       = out_q;

    meta_we     = 1'b0;
    meta_waddr  = slot_q;
    meta_wdata  = '{seq: req_q.sequence_req, frag_count: req_q.fragment_count,
                    recv_count: 8'd0, last_size: 11'd0};
    meta_raddr  = slot_q;
    mark_we     = 1'b0;
    mark_waddr  = {slot_q, clr_q};
    mark_wdata  = 64'd0;
    mark_raddr  = {slot_q, word_sel};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = S_MOD1;
        end
      end
      S_MOD1: begin
        prod_d  = 48'(req_q.sequence_req) * 48'(RECIP);
        state_d = S_MOD2;
      end
      S_MOD2: begin
        slot_d  = SLOT_W'(rem1);
        early_d = early_c;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        res_d = '{status: frt_pkg::ST_OK, packet_complete: 1'b0,
                  complete_sequence: 16'd0, complete_size: 19'd0};
        if (early_q != frt_pkg::ST_OK) begin
          res_d.status = early_q;
          state_d      = S_OUT;
        end else if (valid_q[slot_q] && (meta_rdata.seq != req_q.sequence_req)) begin
          res_d.status = frt_pkg::ST_SLOT_TAKEN;
          state_d      = S_OUT;
        end else if (!valid_q[slot_q]) begin
          old_recv_d = 8'd0;
          old_last_d = 11'd0;
          mword_d    = 64'd0;
          clr_d      = '0;
          if (frt_pkg::seq_newer(req_q.sequence_req, newest_q)) begin
            walk_d  = '0;
            ev_d    = 1'b0;
            state_d = S_ADV;
          end else begin
            state_d = S_CLR;
          end
        end else if (meta_rdata.frag_count != req_q.fragment_count) begin
          res_d.status = frt_pkg::ST_COUNT_DIFF;
          state_d      = S_OUT;
        end else if ((mark_rdata & bit_sel) != 64'd0) begin
          res_d.status = frt_pkg::ST_DUPLICATE;
          state_d      = S_OUT;
        end else begin
          old_recv_d = meta_rdata.recv_count;
          old_last_d = meta_rdata.last_size;
          mword_d    = mark_rdata;
          state_d    = S_UPD;
        end
      end
      S_ADV, S_ADVE: begin
        // Read one record a cycle and retire the one read the cycle before if it is stale.
        if (ev_q && valid_q[ev_idx_q] && frt_pkg::seq_newer(oldest, meta_rdata.seq)) begin
          valid_d[ev_idx_q] = 1'b0;
          buffered_d = (buffered_q > {1'b0, meta_rdata.recv_count}) ?
                       (buffered_q - {1'b0, meta_rdata.recv_count}) : 9'd0;
        end
        if (state_q == S_ADV) begin
          meta_raddr = walk_q;
          ev_d       = 1'b1;
          ev_idx_d   = walk_q;
          walk_d     = walk_q + SLOT_W'(1);
          if (walk_q == LAST_SLOT) begin
            state_d = S_ADVE;
          end
        end else begin
          ev_d     = 1'b0;
          newest_d = req_q.sequence_req;
          state_d  = S_CLR;
        end
      end
      S_CLR: begin
        // Open the slot: write its record once and clear its mark words.
        meta_we = (clr_q == '0);
        mark_we = 1'b1;
        clr_d   = clr_q + WORD_W'(1);
        if (clr_q == LAST_WORD) begin
          valid_d[slot_q] = 1'b1;
          state_d         = S_UPD;
        end
      end
      S_UPD: begin
        meta_we    = 1'b1;
        meta_wdata = '{seq: req_q.sequence_req, frag_count: req_q.fragment_count,
                       recv_count: new_recv, last_size: new_last};
        mark_we    = 1'b1;
        mark_waddr = {slot_q, word_sel};
        mark_wdata = mword_q | bit_sel;
        res_d = '{status: frt_pkg::ST_OK, packet_complete: 1'b0,
                  complete_sequence: 16'd0, complete_size: 19'd0};
        if (new_recv == req_q.fragment_count) begin
          res_d.packet_complete   = 1'b1;
          res_d.complete_sequence = req_q.sequence_req;
          res_d.complete_size     = total[18:0];
          buffered_d = (buf_inc > {1'b0, req_q.fragment_count}) ?
                       (buf_inc - {1'b0, req_q.fragment_count}) : 9'd0;
          valid_d[slot_q] = 1'b0;
        end else begin
          buffered_d = buf_inc;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      newest_q    <= 16'd0;
      buffered_q  <= 9'd0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      ev_q        <= 1'b0;
      mfs_q       <= frt_pkg::MAX_FRAG_SIZE_RST;
      mdist_q     <= frt_pkg::MAX_SEQ_DIST_RST;
      mbuf_q      <= frt_pkg::MAX_BUFFERED_RST;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      buffered_q  <= buffered_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      ev_q        <= ev_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          frt_pkg::CFG_MAX_FRAG_SIZE: mfs_q   <= cfg_data_i[10:0];
          frt_pkg::CFG_MAX_SEQ_DIST:  mdist_q <= cfg_data_i;
          frt_pkg::CFG_MAX_BUFFERED:  mbuf_q  <= cfg_data_i[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    prod_q     <= prod_d;
    slot_q     <= slot_d;
    early_q    <= early_d;
    walk_q     <= walk_d;
    ev_idx_q   <= ev_idx_d;
    clr_q      <= clr_d;
    old_recv_q <= old_recv_d;
    old_last_q <= old_last_d;
    mword_q    <= mword_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

/* rtl/frt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembly tracker checker
// Port-level properties of the requests and responses, bound to the top level.
// ----------------------------------------------------------------------------
module frt_sva (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input frt_pkg::rsp_t out_rsp_o
);

  // A pending response holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // Only an accepted fragment can complete a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.packet_complete |-> out_rsp_o.status == frt_pkg::ST_OK)
    else $error("completion with a failing status");

  // Completion fields are zero unless a packet completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.packet_complete |->
      out_rsp_o.complete_sequence == 16'd0 && out_rsp_o.complete_size == 19'd0)
    else $error("completion fields set without completion");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status <= frt_pkg::ST_DUPLICATE)
    else $error("undefined status code");

  // A new request is never taken in the cycle right after one was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

bind fragment_reassembly_tracker frt_sva u_frt_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
